// File: hw/rtl/swsr_pkg.sv
`default_nettype none
// ============================================================================
// swsr_pkg: shared types for the stack with search and remove
// Holds the beat structs, the operation and status codes and the sizing
// constants used by the cell chain and the top level.
// ============================================================================
package swsr_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 5;
    localparam int MATCH_W       = 4;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic                      top_valid;
        logic [COUNT_W-1:0]        count;
        logic [MATCH_W-1:0]        match_index;
        logic [1:0]                status;
    } rsp_t;

    // Command broadcast to every cell in the chain.
    typedef struct packed {
        logic                      en;
        op_t                       op;
        logic signed [VALUE_W-1:0] key;
    } cell_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/stack_with_search_and_remove.sv
`default_nettype none
// ============================================================================
// stack_with_search_and_remove: bounded LIFO with search and remove
// A chain of cells, top first, holding signed 32-bit entries. Push, pop,
// search and remove each complete in the cycle the request beat is taken.
// ============================================================================
//
//   Channel | Signals                  | Dir | Beat contents
//   --------+--------------------------+-----+-----------------------------------
//   req     | req_valid, req_stall, req| in  | op, value
//   rsp     | rsp_valid, rsp_stall, rsp| out | top_value, top_valid, count,
//           |                          |     | match_index, status
//
// Every request beat gives exactly one response beat. One request is taken per
// cycle while req_stall is low; the whole operation resolves in the cell chain
// in that cycle, where the search ripples a hit flag from the top cell down to
// the bottom cell. The response register captures the result as the request
// is taken. While a response waits under rsp_stall, req_stall is raised; a new
// request is taken in the same cycle that the waiting response beat leaves.
// Reset clears the valid flags of all cells, the fill count and rsp_valid.
//
module stack_with_search_and_remove
#(
    parameter int DEPTH = swsr_pkg::DEPTH_DEFAULT
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire swsr_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output swsr_pkg::rsp_t      rsp
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    // Cell-side signals, index 0 is the top of the stack.
    logic signed [swsr_pkg::VALUE_W-1:0] cell_data      [DEPTH];
    logic                                cell_valid     [DEPTH];
    logic signed [swsr_pkg::VALUE_W-1:0] cell_data_nxt  [DEPTH];
    logic                                cell_valid_nxt [DEPTH];
    logic                                cell_first     [DEPTH];
    logic [DEPTH:0]                      hit_chain;

    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    swsr_pkg::rsp_t      rsp_reg;
    swsr_pkg::rsp_t      rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    swsr_pkg::cell_cmd_t cmd;
    swsr_pkg::op_t       op;
    logic                accept;
    logic                full;
    logic                empty;
    logic                found;
    logic [IDX_W-1:0]    hit_idx;
    logic [swsr_pkg::COUNT_W+FILL_W-1:0] count_ext;
    logic [swsr_pkg::MATCH_W+IDX_W-1:0]  match_ext;

    // A response that cannot leave this cycle holds off the next request.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign op    = swsr_pkg::op_t'(req.op);
    assign full  = (fill_reg == FILL_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign found = hit_chain[DEPTH];

    // Cells only move on an accepted beat. Removal is further gated in each cell
    // by the hit chain, so cells above the first match stay put.
    always_comb
    begin
        cmd.op  = op;
        cmd.key = req.value;
        cmd.en  = 1'b0;
        if (accept)
        begin
            case (op)
                swsr_pkg::OP_PUSH:   cmd.en = !full;
                swsr_pkg::OP_POP:    cmd.en = !empty;
                swsr_pkg::OP_REMOVE: cmd.en = 1'b1;
                default:             cmd.en = 1'b0;
            endcase
        end
    end

    assign hit_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [swsr_pkg::VALUE_W-1:0] up_data;
            logic                                up_valid;
            logic signed [swsr_pkg::VALUE_W-1:0] dn_data;
            logic                                dn_valid;

            // The top cell takes the pushed value; the bottom cell takes an
            // empty slot when the stack closes up.
            if (gi == 0)
            begin : g_top
                assign up_data  = req.value;
                assign up_valid = 1'b1;
            end
            else
            begin : g_mid_up
                assign up_data  = cell_data[gi-1];
                assign up_valid = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_bottom
                assign dn_data  = '0;
                assign dn_valid = 1'b0;
            end
            else
            begin : g_mid_dn
                assign dn_data  = cell_data[gi+1];
                assign dn_valid = cell_valid[gi+1];
            end

            swsr_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .above_data  (up_data),
                .above_valid (up_valid),
                .below_data  (dn_data),
                .below_valid (dn_valid),
                .hit_in      (hit_chain[gi]),
                .hit_out     (hit_chain[gi+1]),
                .first_hit   (cell_first[gi]),
                .data        (cell_data[gi]),
                .valid       (cell_valid[gi]),
                .data_next   (cell_data_nxt[gi]),
                .valid_next  (cell_valid_nxt[gi])
            );
        end
    endgenerate

    // At most one cell reports the first hit, so OR-ing the positions encodes it.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_first[i])
                hit_idx = hit_idx | IDX_W'(i);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.en)
        begin
            case (op)
                swsr_pkg::OP_PUSH:   fill_next = fill_reg + 1'b1;
                swsr_pkg::OP_POP:    fill_next = fill_reg - 1'b1;
                swsr_pkg::OP_REMOVE: fill_next = found ? fill_reg - 1'b1 : fill_reg;
                default:             fill_next = fill_reg;
            endcase
        end
    end

    // The count and match fields wrap to their widths.
    assign count_ext = {{swsr_pkg::COUNT_W{1'b0}}, fill_next};
    assign match_ext = {{swsr_pkg::MATCH_W{1'b0}}, hit_idx};

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.top_valid   = cell_valid_nxt[0];
            rsp_next.top_value   = cell_valid_nxt[0] ? cell_data_nxt[0] : '0;
            rsp_next.count       = count_ext[swsr_pkg::COUNT_W-1:0];
            rsp_next.match_index = '0;
            rsp_next.status      = swsr_pkg::ST_DONE;
            case (op)
                swsr_pkg::OP_PUSH:
                begin
                    if (full)
                        rsp_next.status = swsr_pkg::ST_FULL;
                end
                swsr_pkg::OP_POP:
                begin
                    if (empty)
                        rsp_next.status = swsr_pkg::ST_EMPTY;
                end
                swsr_pkg::OP_SEARCH, swsr_pkg::OP_REMOVE:
                begin
                    if (found)
                        rsp_next.match_index = match_ext[swsr_pkg::MATCH_W-1:0];
                    else
                        rsp_next.status = swsr_pkg::ST_NOT_FOUND;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// File: hw/rtl/swsr_cell.sv
`default_nettype none
// ============================================================================
// swsr_cell: one stack slot
// Holds one entry and its valid flag, compares it against the key and
// shifts toward or away from the top as the command requires.
// ============================================================================
module swsr_cell
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire swsr_pkg::cell_cmd_t                cmd,
    input  wire logic signed [swsr_pkg::VALUE_W-1:0] above_data,
    input  wire logic                               above_valid,
    input  wire logic signed [swsr_pkg::VALUE_W-1:0] below_data,
    input  wire logic                               below_valid,
    input  wire logic                               hit_in,
    output logic                                    hit_out,
    output logic                                    first_hit,
    output logic signed [swsr_pkg::VALUE_W-1:0]     data,
    output logic                                    valid,
    output logic signed [swsr_pkg::VALUE_W-1:0]     data_next,
    output logic                                    valid_next
);

    logic signed [swsr_pkg::VALUE_W-1:0] data_reg;
    logic                                valid_reg;
    logic                                my_hit;
    logic                                take_above;
    logic                                take_below;

    assign my_hit    = valid_reg && (data_reg == cmd.key);
    assign hit_out   = hit_in || my_hit;
    assign first_hit = my_hit && !hit_in;

    always_comb
    begin
        take_above = 1'b0;
        take_below = 1'b0;
        case (cmd.op)
            swsr_pkg::OP_PUSH:   take_above = cmd.en;
            swsr_pkg::OP_POP:    take_below = cmd.en;
            swsr_pkg::OP_REMOVE: take_below = cmd.en && hit_out;
            default:             ;
        endcase
    end

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (take_above)
        begin
            data_next  = above_data;
            valid_next = above_valid;
        end
        else if (take_below)
        begin
            data_next  = below_data;
            valid_next = below_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule
`default_nettype wire

// File: verif/stack_with_search_and_remove_tb.sv
// ============================================================================
// stack_with_search_and_remove_tb: self-checking bench for the search stack
// Drives push, pop, search and remove beats into the block and checks every
// response beat against an in-bench model of the bounded LIFO.
// ============================================================================
module stack_with_search_and_remove_tb;

    localparam int STACK_DEPTH    = swsr_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 500;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // The response is registered, so quiet cycles after the last prediction is
    // matched are enough to catch a stray response beat.
    localparam int DRAIN_CYCLES   = 8;

    // Bias of the random operation mix over one stretch of traffic.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;

    // Shape of the back-pressure that the response side applies.
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    swsr_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    swsr_pkg::rsp_t rsp;

    // Model of the stack contents, bottom entry at index 0.
    logic signed [swsr_pkg::VALUE_W-1:0] model_entries [STACK_DEPTH];
    int                                  model_fill = 0;

    // Responses predicted for accepted requests, oldest first.
    swsr_pkg::rsp_t expected_beats [$];
    int             mismatch_count = 0;
    int             burst_left     = 0;

    stack_with_search_and_remove u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one operation to the model and returns the response beat that the
    // block must produce for it. Search and remove scan from the top down, so
    // among equal entries the one nearest the top wins.
    function automatic swsr_pkg::rsp_t apply_stack_op(swsr_pkg::op_t op,
                                                      logic signed [swsr_pkg::VALUE_W-1:0] key);
        swsr_pkg::rsp_t result;
        int             hit_pos;
        result        = '0;
        result.status = swsr_pkg::ST_DONE;
        case (op)
            swsr_pkg::OP_PUSH:
            begin
                if (model_fill >= STACK_DEPTH)
                    result.status = swsr_pkg::ST_FULL;
                else
                begin
                    model_entries[model_fill] = key;
                    model_fill++;
                end
            end
            swsr_pkg::OP_POP:
            begin
                if (model_fill == 0)
                    result.status = swsr_pkg::ST_EMPTY;
                else
                    model_fill--;
            end
            default:
            begin
                hit_pos = -1;
                for (int depth = 0; depth < model_fill; depth++)
                begin
                    if (hit_pos < 0 && model_entries[model_fill - 1 - depth] == key)
                    begin
                        hit_pos            = model_fill - 1 - depth;
                        result.match_index = swsr_pkg::MATCH_W'(depth);
                    end
                end
                if (hit_pos < 0)
                    result.status = swsr_pkg::ST_NOT_FOUND;
                else if (op == swsr_pkg::OP_REMOVE)
                begin
                    // Entries below the hit keep their order; those above it
                    // move down one place to close the gap.
                    for (int pos = hit_pos; pos + 1 < model_fill; pos++)
                        model_entries[pos] = model_entries[pos + 1];
                    model_fill--;
                end
            end
        endcase
        result.top_valid = (model_fill > 0);
        result.top_value = (model_fill > 0) ? model_entries[model_fill - 1] : '0;
        result.count     = swsr_pkg::COUNT_W'(model_fill);
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Sends one request beat. The sender works in bursts: when a burst runs out
    // it drops valid for a random gap and then starts a new burst, sometimes a
    // long one so that stretches without idling also occur. Valid is raised at
    // the falling edge and held, with the payload unchanged, until the beat is
    // taken at a rising edge with req_stall low.
    task automatic send_beat(input swsr_pkg::op_t op,
                             input logic signed [swsr_pkg::VALUE_W-1:0] value);
        int idle_gap;
        if (burst_left == 0)
        begin
            idle_gap = $urandom_range(1, 6);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (idle_gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= swsr_pkg::req_t'{op: op, value: value};
        forever
        begin
            @(posedge clk);
            if (req_stall === 1'b0)
                break;
        end
        expected_beats.push_back(apply_stack_op(op, value));
        burst_left--;
    endtask

    // A few values that stress the compare: both signed extremes, zero, all
    // ones and small numbers that repeat often enough to give duplicates.
    function automatic logic signed [swsr_pkg::VALUE_W-1:0] pool_value(int idx);
        case (idx)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return 32'sd42;
        endcase
    endfunction

    // Value for a push: half from the pool, half fully random so that every
    // bit of the field sees both levels.
    function automatic logic signed [swsr_pkg::VALUE_W-1:0] pick_push_value();
        if ($urandom_range(0, 1) == 0)
            return pool_value($urandom_range(0, 5));
        return $urandom;
    endfunction

    // Key for a search or remove: mostly an entry that is held, taken at any
    // depth so that hits reach the bottom of a full stack, and otherwise a pool
    // value or a random word that will usually miss.
    function automatic logic signed [swsr_pkg::VALUE_W-1:0] pick_search_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (model_fill > 0 && roll < 65)
            return model_entries[$urandom_range(0, model_fill - 1)];
        if (roll < 85)
            return pool_value($urandom_range(0, 5));
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------

    // The receiver moves between stall patterns of random length: none, light,
    // heavy and a fixed periodic one, so that stalls land on every phase of
    // the request bursts.
    initial
    begin : rsp_stall_pattern
        stall_mode_t mode;
        int          mode_left;
        int          phase;
        mode_left = 0;
        phase     = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 160);
            end
            mode_left--;
            phase++;
            case (mode)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
                STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default:     rsp_stall <= ((phase % 7) < 3);
            endcase
        end
    end

    task automatic check_field(input string name,
                               input logic [swsr_pkg::VALUE_W-1:0] exp_val,
                               input logic [swsr_pkg::VALUE_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Every response beat taken is compared with the oldest prediction.
    always @(posedge clk)
    begin : rsp_checker
        swsr_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("response beat arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                exp_rsp = expected_beats.pop_front();
                check_field("top_value",   exp_rsp.top_value,   rsp.top_value);
                check_field("top_valid",   exp_rsp.top_valid,   rsp.top_valid);
                check_field("count",       exp_rsp.count,       rsp.count);
                check_field("match_index", exp_rsp.match_index, rsp.match_index);
                check_field("status",      exp_rsp.status,      rsp.status);
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("stack_with_search_and_remove_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Operations on an empty stack, then popping the only entry, which must
    // leave the top cleared to zero and its valid flag low.
    task automatic test_empty_stack();
        send_beat(swsr_pkg::OP_POP,    32'sd0);
        send_beat(swsr_pkg::OP_SEARCH, 32'sd0);
        send_beat(swsr_pkg::OP_REMOVE, -32'sd1);
        send_beat(swsr_pkg::OP_PUSH,   32'sd5);
        send_beat(swsr_pkg::OP_POP,    32'sd0);
    endtask

    // Both signed extremes, zero and all ones go through push and compare.
    task automatic test_value_extremes();
        send_beat(swsr_pkg::OP_PUSH,   32'sh8000_0000);
        send_beat(swsr_pkg::OP_PUSH,   32'sh7FFF_FFFF);
        send_beat(swsr_pkg::OP_PUSH,   32'sh0000_0000);
        send_beat(swsr_pkg::OP_PUSH,   -32'sd1);
        send_beat(swsr_pkg::OP_SEARCH, 32'sh8000_0000);
    endtask

    // Two equal entries: search and remove must pick the one nearer the top,
    // and a remove of the top entry must expose the one below it.
    task automatic test_duplicates_and_remove();
        send_beat(swsr_pkg::OP_PUSH,   32'sd7);
        send_beat(swsr_pkg::OP_PUSH,   32'sd7);
        send_beat(swsr_pkg::OP_PUSH,   32'sd9);
        send_beat(swsr_pkg::OP_SEARCH, 32'sd7);
        send_beat(swsr_pkg::OP_REMOVE, 32'sd7);
        send_beat(swsr_pkg::OP_SEARCH, 32'sd7);
        send_beat(swsr_pkg::OP_REMOVE, 32'sd9);
    endtask

    // Fills the stack, pushes once more into the full stack, then finds and
    // removes the bottom entry, which sits at the deepest match index.
    task automatic test_full_stack();
        while (model_fill < STACK_DEPTH)
            send_beat(swsr_pkg::OP_PUSH, $urandom_range(100, 100000));
        send_beat(swsr_pkg::OP_PUSH,   32'sd11);
        send_beat(swsr_pkg::OP_SEARCH, model_entries[0]);
        send_beat(swsr_pkg::OP_REMOVE, model_entries[0]);
    endtask

    // Stretches of fill-heavy, drain-heavy and balanced traffic. Filling runs
    // the stack into the full case and draining into the empty one, while the
    // keys mostly hit held entries so that removes really reshape the stack.
    task automatic test_random_traffic();
        op_mix_t       mix;
        int            stretch;
        int            roll;
        int            sent;
        swsr_pkg::op_t op;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mix     = op_mix_t'($urandom_range(0, 2));
            stretch = $urandom_range(10, 50);
            repeat (stretch)
            begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:
                        op = (roll < 60) ? swsr_pkg::OP_PUSH
                           : (roll < 70) ? swsr_pkg::OP_POP
                           : (roll < 85) ? swsr_pkg::OP_SEARCH : swsr_pkg::OP_REMOVE;
                    MIX_DRAIN:
                        op = (roll < 10) ? swsr_pkg::OP_PUSH
                           : (roll < 60) ? swsr_pkg::OP_POP
                           : (roll < 75) ? swsr_pkg::OP_SEARCH : swsr_pkg::OP_REMOVE;
                    default:
                        op = swsr_pkg::op_t'(roll % 4);
                endcase
                if (op == swsr_pkg::OP_PUSH)
                    send_beat(op, pick_push_value());
                else if (op == swsr_pkg::OP_POP)
                    send_beat(op, $urandom);
                else
                    send_beat(op, pick_search_key());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_value_extremes();
        test_duplicates_and_remove();
        test_full_stack();
        test_random_traffic();

        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("stack_with_search_and_remove_tb: PASS");
        else
            $display("stack_with_search_and_remove_tb: FAIL");
        $finish;
    end

endmodule
